// ----- src/eio_pkg.sv -----
package eio_pkg;

    // Record and arithmetic widths
    localparam int CNT_W     = 40;
    localparam int DUR_W     = 24;
    localparam int START_W   = 40;
    localparam int Q16_W     = 16;
    localparam int TIME_W    = 41;
    localparam int HAZ_W     = 40;
    localparam int BSUM_W    = 28;
    localparam int MIN_W     = 19;
    localparam int BUCKETS   = 10;
    localparam int TERMS     = 12;
    localparam int EXP_LIMIT = 18;
    localparam int IN_DATA_W = 192;
    localparam int OUT_DATA_W = 64;

    localparam logic [HAZ_W-1:0] HAZ_MAX     = {HAZ_W{1'b1}};
    localparam logic [DUR_W:0]   RECIP_60    = 25'd17895697;
    localparam logic [6:0]       SIXTY       = 7'd60;
    localparam logic [3:0]       LAST_TERM   = 4'd12;

    // Datapath commands, one per controller step
    typedef struct packed {
        logic load;
        logic haz;
        logic sc1;
        logic sc2;
        logic acc;
        logic exi;
        logic tmul;
        logic trcp;
        logic tfix;
        logic fin;
        logic emit;
    } eio_cmd_t;

    typedef struct packed {
        logic last;
        logic term_done;
        logic out_full;
    } eio_stat_t;

    // Sigmoid weight at bucket midpoint, Q0.16
    function automatic logic [15:0] bucket_weight(input logic [3:0] i);
        logic [15:0] w;
        case (i)
            4'd0:    w = 16'd65348;
            4'd1:    w = 16'd64701;
            4'd2:    w = 16'd61952;
            4'd3:    w = 16'd52044;
            4'd4:    w = 16'd30315;
            4'd5:    w = 16'd10558;
            4'd6:    w = 16'd2693;
            4'd7:    w = 16'd621;
            4'd8:    w = 16'd140;
            4'd9:    w = 16'd31;
            default: w = 16'd0;
        endcase
        return w;
    endfunction

    // exp(-n), Q0.24
    function automatic logic [24:0] exp_neg_int(input logic [4:0] n);
        logic [24:0] e;
        case (n)
            5'd0:    e = 25'd16777216;
            5'd1:    e = 25'd6171993;
            5'd2:    e = 25'd2270549;
            5'd3:    e = 25'd835288;
            5'd4:    e = 25'd307285;
            5'd5:    e = 25'd113044;
            5'd6:    e = 25'd41587;
            5'd7:    e = 25'd15299;
            5'd8:    e = 25'd5628;
            5'd9:    e = 25'd2070;
            5'd10:   e = 25'd762;
            5'd11:   e = 25'd280;
            5'd12:   e = 25'd103;
            5'd13:   e = 25'd38;
            5'd14:   e = 25'd14;
            5'd15:   e = 25'd5;
            5'd16:   e = 25'd2;
            5'd17:   e = 25'd1;
            default: e = 25'd0;
        endcase
        return e;
    endfunction

    // floor((2^32-1)/k); quotient estimate is low by at most one
    function automatic logic [31:0] recip_k(input logic [3:0] k);
        logic [31:0] r;
        case (k)
            4'd1:    r = 32'd4294967295;
            4'd2:    r = 32'd2147483647;
            4'd3:    r = 32'd1431655765;
            4'd4:    r = 32'd1073741823;
            4'd5:    r = 32'd858993459;
            4'd6:    r = 32'd715827882;
            4'd7:    r = 32'd613566756;
            4'd8:    r = 32'd536870911;
            4'd9:    r = 32'd477218588;
            4'd10:   r = 32'd429496729;
            4'd11:   r = 32'd390451572;
            4'd12:   r = 32'd357913941;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- src/exposure_infection_outcome.sv -----
// Exposure infection outcome.
// Input channel s_axis_*: one exposure record per word; tlast marks the last
// record of a set. Output channel m_axis_*: one outcome word per set, given
// after the word with tlast; other records give nothing.
// Each record passes capture, bucket sum, two scaling multiplies and
// accumulate before the next word is taken. The last record then adds
// exp(-hazard): setup, 12 series terms, each a multiply, a reciprocal step
// and a remainder fix, then the table product and emit.
// s_axis_tready is high only while the block waits for a record.
// Records with zero infectivity add no hazard and do not move the end time.
// The outcome sits in an output register; while the receiver stalls, the
// block keeps taking records of the next set and waits at the next emit
// only if the register is still full.
// Reset clears the hazard sum, latest end time and output valid; the hazard
// sum and latest end time clear again after each emitted outcome.
module exposure_infection_outcome
    import eio_pkg::*;
#(
    parameter int PROB_FRAC_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // counts_near, counts_far, duration_seconds, start_seconds,
    // infectivity, symptom scale, random_draw
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // became_exposed, infection_time, had_infectious,
    // infection_probability, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    eio_cmd_t  cmd;
    eio_stat_t stat;

    eio_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    eio_datapath #(
        .PROB_FRAC_BITS (PROB_FRAC_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_data   (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule

// ----- src/eio_ctrl.sv -----
module eio_ctrl
    import eio_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  logic      out_ready,
    input  eio_stat_t stat,
    output eio_cmd_t  cmd
);

    typedef enum logic [10:0] {
        IDLE = 11'b000_0000_0001,
        HAZ  = 11'b000_0000_0010,
        SC1  = 11'b000_0000_0100,
        SC2  = 11'b000_0000_1000,
        ACC  = 11'b000_0001_0000,
        EXI  = 11'b000_0010_0000,
        TMUL = 11'b000_0100_0000,
        TRCP = 11'b000_1000_0000,
        TFIX = 11'b001_0000_0000,
        FIN  = 11'b010_0000_0000,
        OUTW = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   emit;

    assign in_ready = (state_reg == IDLE);
    assign emit     = (state_reg == OUTW) && (!stat.out_full || out_ready);

    // Commands
    always_comb
    begin
        cmd      = '0;
        cmd.load = (state_reg == IDLE) && in_valid;
        cmd.haz  = (state_reg == HAZ);
        cmd.sc1  = (state_reg == SC1);
        cmd.sc2  = (state_reg == SC2);
        cmd.acc  = (state_reg == ACC);
        cmd.exi  = (state_reg == EXI);
        cmd.tmul = (state_reg == TMUL);
        cmd.trcp = (state_reg == TRCP);
        cmd.tfix = (state_reg == TFIX);
        cmd.fin  = (state_reg == FIN);
        cmd.emit = emit;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            IDLE: if (in_valid) state_next = HAZ;
            HAZ:  state_next = SC1;
            SC1:  state_next = SC2;
            SC2:  state_next = ACC;
            ACC:  state_next = stat.last ? EXI : IDLE;
            EXI:  state_next = TMUL;
            TMUL: state_next = TRCP;
            TRCP: state_next = TFIX;
            TFIX: state_next = stat.term_done ? FIN : TMUL;
            FIN:  state_next = OUTW;
            OUTW: if (emit) state_next = IDLE;
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= IDLE;
        else
            state_reg <= state_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("controller state not one-hot");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ACC) && !stat.last |=> (state_reg == IDLE))
        else $error("non-last word did not return to idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (state_reg == IDLE))
        else $error("emit did not end the set");

endmodule

// ----- src/eio_datapath.sv -----
module eio_datapath
    import eio_pkg::*;
#(
    parameter int PROB_FRAC_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  eio_cmd_t              cmd,
    output eio_stat_t             stat,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  logic                  in_last,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [OUT_DATA_W-1:0] out_data
);

    localparam int PW = PROB_FRAC_BITS + 1;

    // Captured record
    logic [CNT_W-1:0]   near_reg, far_reg;
    logic [DUR_W-1:0]   dur_reg;
    logic [START_W-1:0] start_reg;
    logic [Q16_W-1:0]   inf_reg, sym_reg, u_reg;
    logic               last_reg;

    // Hazard pipeline
    logic [BSUM_W-1:0]  bsum_reg;
    logic               allz_reg;
    logic [MIN_W-1:0]   q60_reg;
    logic [TIME_W-1:0]  end_reg;
    logic [38:0]        h1_reg;
    logic [42:0]        h2_reg;

    // Set state
    logic [HAZ_W-1:0]   sum_reg;
    logic [TIME_W-1:0]  latest_reg;
    logic               seen_reg;

    // Exponential unit
    logic               nbig_reg;
    logic [4:0]         nidx_reg;
    logic [31:0]        f_reg;
    logic [32:0]        term_reg, accx_reg;
    logic [3:0]         k_reg;
    logic [31:0]        x_reg, y_reg;
    logic [24:0]        e24_reg;

    // Output word
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;

    // Combinational terms
    logic [BSUM_W-1:0]  bsum_c;
    logic               allz_c;
    logic [7:0]         cnt;
    logic [48:0]        q60_prod;
    logic [DUR_W-1:0]   r60;
    logic [MIN_W-1:0]   minutes;
    logic [34:0]        hsel;
    logic [50:0]        p1;
    logic [54:0]        p2;
    logic [43:0]        sum_ext;
    logic [63:0]        tprod, rprod;
    logic [31:0]        rk, qk;
    logic [56:0]        eprod;
    logic [PW-1:0]      e_w, p_w;
    logic [PW+16:0]     lhs, rhs;
    logic [PW+15:0]     p_sh;
    logic [16:0]        prob;

    assign stat.last      = last_reg;
    assign stat.term_done = (k_reg == LAST_TERM);
    assign stat.out_full  = out_valid_reg;
    assign out_valid      = out_valid_reg;
    assign out_data       = out_data_reg;

    // Weighted bucket sum
    always_comb
    begin
        bsum_c = '0;
        allz_c = 1'b1;
        cnt    = '0;
        for (int i = 0; i < BUCKETS; i++)
        begin
            cnt = (i < 5) ? near_reg[8*(i%5) +: 8] : far_reg[8*(i%5) +: 8];
            if (cnt != 8'd0)
                allz_c = 1'b0;
            bsum_c = bsum_c + BSUM_W'(cnt) * BSUM_W'(bucket_weight(4'(i)));
        end
    end

    assign q60_prod = 49'(dur_reg) * 49'(RECIP_60);

    // Minutes correction and hazard select
    always_comb
    begin
        r60     = dur_reg - DUR_W'(q60_reg * 26'(SIXTY));
        minutes = (r60 >= DUR_W'(SIXTY)) ? q60_reg + 1'b1 : q60_reg;
        hsel    = (allz_reg && (dur_reg > DUR_W'(SIXTY))) ? {minutes, 16'h0}
                                                          : 35'(bsum_reg);
    end

    assign p1      = 51'(hsel) * 51'(inf_reg);
    assign p2      = 55'(h1_reg) * 55'(sym_reg);
    assign sum_ext = 44'(sum_reg) + 44'(h2_reg);

    // Series step: term*f, reciprocal, remainder fix
    assign tprod = term_reg[31:0] * f_reg;
    assign rprod = x_reg * recip_k(k_reg);
    always_comb
    begin
        rk = x_reg - 32'(y_reg * k_reg);
        qk = (rk >= 32'(k_reg)) ? y_reg + 1'b1 : y_reg;
    end
    assign eprod = 57'(exp_neg_int(nidx_reg)) * 57'(accx_reg[31:0]);

    // Probability and draw
    always_comb
    begin
        e_w  = PW'(e24_reg >> (24 - PROB_FRAC_BITS));
        p_w  = (PW'(1) << PROB_FRAC_BITS) - e_w;
        lhs  = (PW+17)'({u_reg, {PROB_FRAC_BITS{1'b0}}});
        rhs  = (PW+17)'({p_w, 16'h0});
        p_sh = {p_w, 16'h0} >> PROB_FRAC_BITS;
        prob = p_sh[16:0];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            near_reg  <= in_data[39:0];
            far_reg   <= in_data[79:40];
            dur_reg   <= in_data[103:80];
            start_reg <= in_data[143:104];
            inf_reg   <= in_data[159:144];
            sym_reg   <= in_data[175:160];
            u_reg     <= in_data[191:176];
            last_reg  <= in_last;
        end
        if (cmd.haz)
        begin
            bsum_reg <= bsum_c;
            allz_reg <= allz_c;
            q60_reg  <= q60_prod[48:30];
            end_reg  <= TIME_W'(start_reg) + TIME_W'(dur_reg);
        end
        if (cmd.sc1)
            h1_reg <= p1[50:12];
        if (cmd.sc2)
            h2_reg <= p2[54:12];
        if (cmd.exi)
        begin
            nbig_reg <= (sum_reg[39:16] >= 24'(EXP_LIMIT));
            nidx_reg <= sum_reg[20:16];
            f_reg    <= {sum_reg[15:0], 16'h0};
            term_reg <= 33'h1_0000_0000;
            accx_reg <= 33'h1_0000_0000;
            k_reg    <= 4'd1;
        end
        if (cmd.tmul)
            x_reg <= term_reg[32] ? f_reg : tprod[63:32];
        if (cmd.trcp)
            y_reg <= rprod[63:32];
        if (cmd.tfix)
        begin
            term_reg <= {1'b0, qk};
            accx_reg <= k_reg[0] ? accx_reg - 33'(qk) : accx_reg + 33'(qk);
            k_reg    <= k_reg + 1'b1;
        end
        if (cmd.fin)
        begin
            if (nbig_reg)
                e24_reg <= '0;
            else if (accx_reg[32])
                e24_reg <= exp_neg_int(nidx_reg);
            else
                e24_reg <= eprod[56:32];
        end
        if (cmd.emit)
        begin
            out_data_reg[0]     <= (lhs < rhs);
            out_data_reg[41:1]  <= seen_reg ? latest_reg : '0;
            out_data_reg[42]    <= seen_reg;
            out_data_reg[59:43] <= prob;
            out_data_reg[63:60] <= '0;
        end
    end

    // Set state and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            latest_reg    <= '0;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.acc && (inf_reg != '0))
            begin
                sum_reg  <= (sum_ext > 44'(HAZ_MAX)) ? HAZ_MAX : sum_ext[HAZ_W-1:0];
                if (!seen_reg || (end_reg > latest_reg))
                    latest_reg <= end_reg;
                seen_reg <= 1'b1;
            end
            else if (cmd.emit)
            begin
                sum_reg    <= '0;
                latest_reg <= '0;
                seen_reg   <= 1'b0;
            end
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tmul |-> (k_reg >= 4'd1) && (k_reg <= LAST_TERM))
        else $error("series index out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (sum_reg == '0) && !seen_reg && out_valid_reg)
        else $error("set state not cleared on emit");
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tfix |-> (accx_reg <= 33'h1_0000_0000))
        else $error("series accumulator above one");

endmodule
